// ===== rtl/vfa_pkg.sv =====
// shared types and constants for the q16.16 vector alu
// no dependencies; imported by every module of the block
package vfa_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [31:0] INT32_MAX_U = 32'h7fff_ffff;
    localparam logic [31:0] INT32_MIN_U = 32'h8000_0000;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_DOT   = 3'd2,
        CMD_SCALE = 3'd3,
        CMD_CROSS = 3'd4,
        CMD_LEN   = 3'd5,
        CMD_NORM  = 3'd6
    } t_cmd;

    // item bookkeeping carried alongside the square root and divide pipes
    typedef struct packed {
        t_cmd             cmd;
        logic [2:0][31:0] res;
        logic             flag;
        logic [4:0]       k;
        logic [2:0]       sgn;
        logic [2:0][31:0] mag;
    } t_side;

endpackage

// ===== rtl/vfa_front.sv =====
// front end: input register, multipliers, product sums, rounding, saturation
// and the normalizing shift of the squared length; uses vfa_pkg
module vfa_front import vfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic signed [31:0] i_scalar,
    output logic               o_vld,
    output logic [63:0]        o_rad,
    output t_side              o_side
);

    localparam logic signed [65:0] Half = 66'sd1 <<< (FRAC_BITS - 1);

    function automatic logic [4:0] lzc16(input logic [15:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd16;
        hit = 1'b0;
        for (int i = 15; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 5'(15 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // stage 1: input register
    logic               r1_vld;
    t_cmd               r1_cmd;
    logic signed [31:0] r1_a [0:2];
    logic signed [31:0] r1_b [0:2];
    logic signed [31:0] r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cmd  <= t_cmd'(i_command);
        r1_a[0] <= i_ax;
        r1_a[1] <= i_ay;
        r1_a[2] <= i_az;
        r1_b[0] <= i_bx;
        r1_b[1] <= i_by;
        r1_b[2] <= i_bz;
        r1_s    <= i_scalar;
    end

    // stage 2: six multipliers, add/sub with saturation, magnitudes
    logic signed [31:0] n_opa [0:5];
    logic signed [31:0] n_opb [0:5];
    logic signed [63:0] n_m   [0:5];
    logic signed [32:0] n_sum [0:2];
    logic [31:0]        n_as  [0:2];
    logic [2:0]         n_asov;
    logic [31:0]        n_mag [0:2];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_opa[i] = '0;
            n_opb[i] = '0;
        end
        case (r1_cmd) inside
            CMD_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    n_opa[i] = r1_a[i];
                    n_opb[i] = r1_b[i];
                end
            end
            CMD_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_opa[i] = r1_a[i];
                    n_opb[i] = r1_s;
                end
            end
            CMD_CROSS: begin
                n_opa[0] = r1_a[1]; n_opb[0] = r1_b[2];
                n_opa[1] = r1_a[2]; n_opb[1] = r1_b[0];
                n_opa[2] = r1_a[0]; n_opb[2] = r1_b[1];
                n_opa[3] = r1_a[2]; n_opb[3] = r1_b[1];
                n_opa[4] = r1_a[0]; n_opb[4] = r1_b[2];
                n_opa[5] = r1_a[1]; n_opb[5] = r1_b[0];
            end
            CMD_LEN, CMD_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    n_opa[i] = r1_a[i];
                    n_opb[i] = r1_a[i];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_m[i] = n_opa[i] * n_opb[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (r1_cmd == CMD_SUB) begin
                n_sum[i] = {r1_a[i][31], r1_a[i]} - {r1_b[i][31], r1_b[i]};
            end else begin
                n_sum[i] = {r1_a[i][31], r1_a[i]} + {r1_b[i][31], r1_b[i]};
            end
            n_asov[i] = n_sum[i][32] != n_sum[i][31];
            if (n_asov[i]) begin
                n_as[i] = n_sum[i][32] ? INT32_MIN_U : INT32_MAX_U;
            end else begin
                n_as[i] = n_sum[i][31:0];
            end
            n_mag[i] = r1_a[i][31] ? 32'(-r1_a[i]) : r1_a[i];
        end
    end

    logic               r2_vld;
    t_cmd               r2_cmd;
    logic signed [63:0] r2_m   [0:5];
    logic [31:0]        r2_as  [0:2];
    logic               r2_asf;
    logic [31:0]        r2_mag [0:2];
    logic [2:0]         r2_sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_cmd <= r1_cmd;
        for (int i = 0; i < 6; i++) begin
            r2_m[i] <= n_m[i];
        end
        for (int i = 0; i < 3; i++) begin
            r2_as[i]  <= n_as[i];
            r2_mag[i] <= n_mag[i];
            r2_sgn[i] <= r1_a[i][31];
        end
        r2_asf <= |n_asov;
    end

    // stage 3: exact product sums
    logic signed [65:0] n_e [0:2];
    logic signed [65:0] n_mx [0:5];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_mx[i] = {{2{r2_m[i][63]}}, r2_m[i]};
        end
        for (int i = 0; i < 3; i++) begin
            n_e[i] = '0;
        end
        case (r2_cmd) inside
            CMD_DOT, CMD_LEN, CMD_NORM: begin
                n_e[0] = n_mx[0] + n_mx[1] + n_mx[2];
            end
            CMD_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_e[i] = n_mx[i];
                end
            end
            CMD_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    n_e[i] = n_mx[i] - n_mx[i + 3];
                end
            end
            default: begin
            end
        endcase
    end

    logic               r3_vld;
    t_cmd               r3_cmd;
    logic signed [65:0] r3_e   [0:2];
    logic [31:0]        r3_as  [0:2];
    logic               r3_asf;
    logic [31:0]        r3_mag [0:2];
    logic [2:0]         r3_sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_cmd <= r2_cmd;
        r3_e   <= n_e;
        r3_as  <= r2_as;
        r3_asf <= r2_asf;
        r3_mag <= r2_mag;
        r3_sgn <= r2_sgn;
    end

    // stage 4: round half up, saturate, pick the simple result; chunk zero counts
    logic signed [65:0] n_rd  [0:2];
    logic [31:0]        n_rs  [0:2];
    logic [2:0]         n_rov;
    logic [31:0]        n_res [0:2];
    logic               n_flag;
    logic [63:0]        n_sq;
    logic [4:0]         n_lzc [0:3];
    logic [3:0]         n_cz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rd[i]  = (r3_e[i] + Half) >>> FRAC_BITS;
            n_rov[i] = !((&n_rd[i][65:31]) || !(|n_rd[i][65:31]));
            if (n_rov[i]) begin
                n_rs[i] = n_rd[i][65] ? INT32_MIN_U : INT32_MAX_U;
            end else begin
                n_rs[i] = n_rd[i][31:0];
            end
            n_res[i] = '0;
        end
        n_flag = 1'b0;
        case (r3_cmd) inside
            CMD_ADD, CMD_SUB: begin
                n_res  = r3_as;
                n_flag = r3_asf;
            end
            CMD_DOT: begin
                n_res[0] = n_rs[0];
                n_flag   = n_rov[0];
            end
            CMD_SCALE, CMD_CROSS: begin
                n_res  = n_rs;
                n_flag = |n_rov;
            end
            default: begin
            end
        endcase
        n_sq = r3_e[0][63:0];
        for (int c = 0; c < 4; c++) begin
            n_lzc[c] = lzc16(n_sq[16*c +: 16]);
            n_cz[c]  = ~(|n_sq[16*c +: 16]);
        end
    end

    logic        r4_vld;
    t_cmd        r4_cmd;
    logic [31:0] r4_res [0:2];
    logic        r4_flag;
    logic [63:0] r4_sq;
    logic [4:0]  r4_lzc [0:3];
    logic [3:0]  r4_cz;
    logic [31:0] r4_mag [0:2];
    logic [2:0]  r4_sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_cmd  <= r3_cmd;
        r4_res  <= n_res;
        r4_flag <= n_flag;
        r4_sq   <= n_sq;
        r4_lzc  <= n_lzc;
        r4_cz   <= n_cz;
        r4_mag  <= r3_mag;
        r4_sgn  <= r3_sgn;
    end

    // stage 5: leading zero count of the squared length, shift pair count k
    logic [6:0] n_lz;
    logic [6:0] n_lzm2;
    logic [4:0] n_k;
    logic       n_zero;

    always_comb begin
        if (!r4_cz[3]) begin
            n_lz = {2'b00, r4_lzc[3]};
        end else if (!r4_cz[2]) begin
            n_lz = 7'd16 + {2'b00, r4_lzc[2]};
        end else if (!r4_cz[1]) begin
            n_lz = 7'd32 + {2'b00, r4_lzc[1]};
        end else begin
            n_lz = 7'd48 + {2'b00, r4_lzc[0]};
        end
        n_lzm2 = n_lz - 7'd2;
        n_k    = (n_lz < 7'd2) ? 5'd0 : n_lzm2[5:1];
        n_zero = &r4_cz;
    end

    logic        r5_vld;
    t_side       r5_side;
    logic [63:0] r5_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_side.cmd  <= r4_cmd;
        for (int i = 0; i < 3; i++) begin
            r5_side.res[i] <= r4_res[i];
            r5_side.mag[i] <= r4_mag[i];
        end
        r5_side.flag <= r4_flag | ((r4_cmd == CMD_NORM) & n_zero);
        r5_side.k    <= n_k;
        r5_side.sgn  <= r4_sgn;
        r5_sq        <= r4_sq;
    end

    // stage 6: normalizing shift, radicand select
    logic [63:0] n_rad;

    always_comb begin
        if (r5_side.cmd == CMD_LEN) begin
            n_rad = r5_sq;
        end else begin
            n_rad = r5_sq << {r5_side.k, 1'b0};
        end
    end

    logic        r6_vld;
    logic [63:0] r6_rad;
    t_side       r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_rad  <= n_rad;
        r6_side <= r5_side;
    end

    assign o_vld  = r6_vld;
    assign o_rad  = r6_rad;
    assign o_side = r6_side;

endmodule

// ===== rtl/vfa_sqrt.sv =====
// pipelined integer square root, one root bit per stage, 64-bit radicand
// uses vfa_pkg for the item bookkeeping that rides along
module vfa_sqrt import vfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [63:0] i_rad,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [31:0] o_root,
    output logic [32:0] o_rem,
    output t_side       o_side
);

    localparam int Steps = 32;

    logic        r_vld  [1:Steps];
    logic [63:0] r_rem  [1:Steps];
    logic [31:0] r_root [1:Steps];
    t_side       r_side [1:Steps];

    for (genvar g = 0; g < Steps; g++) begin : g_stage
        localparam int J = Steps - 1 - g;

        logic        c_vld;
        logic [63:0] c_rem;
        logic [31:0] c_root;
        t_side       c_side;
        logic [65:0] n_trial;
        logic        n_take;

        if (g == 0) begin : g_first
            assign c_vld  = i_vld;
            assign c_rem  = i_rad;
            assign c_root = '0;
            assign c_side = i_side;
        end else begin : g_next
            assign c_vld  = r_vld[g];
            assign c_rem  = r_rem[g];
            assign c_root = r_root[g];
            assign c_side = r_side[g];
        end

        // (root + 2^j)^2 - root^2
        assign n_trial = ({34'd0, c_root} << (J + 1)) + (66'd1 << (2 * J));
        assign n_take  = {2'b00, c_rem} >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (n_take) begin
                r_rem[g+1]  <= c_rem - n_trial[63:0];
                r_root[g+1] <= c_root | (32'd1 << J);
            end else begin
                r_rem[g+1]  <= c_rem;
                r_root[g+1] <= c_root;
            end
            r_side[g+1] <= c_side;
        end
    end

    assign o_vld  = r_vld[Steps];
    assign o_root = r_root[Steps];
    assign o_rem  = r_rem[Steps][32:0];
    assign o_side = r_side[Steps];

endmodule

// ===== rtl/vfa_div.sv =====
// length rounding and three pipelined restoring dividers for normalize
// uses vfa_pkg; fed by vfa_sqrt
module vfa_div import vfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [31:0]             i_root,
    input  logic [32:0]             i_rem,
    input  t_side                   i_side,
    output logic                    o_vld,
    output logic [2:0][FRAC_BITS:0] o_q,
    output t_side                   o_side
);

    localparam int NumW  = 33 + FRAC_BITS;
    localparam int QuoW  = FRAC_BITS + 1;
    localparam int Steps = QuoW;

    // prep stage: round the length, build numerators with half the divisor
    logic [32:0]     n_len;
    logic            n_lsat;
    logic [5:0]      n_sh;
    logic [NumW-1:0] n_num [0:2];
    t_side           n_side;

    always_comb begin
        n_len  = {1'b0, i_root} + {32'd0, (i_rem > {1'b0, i_root})};
        n_lsat = |n_len[32:31];
        n_side = i_side;
        if (i_side.cmd == CMD_LEN) begin
            n_side.res[0] = n_lsat ? INT32_MAX_U : n_len[31:0];
            n_side.flag   = n_lsat;
        end
        n_sh = 6'(FRAC_BITS) + {1'b0, i_side.k};
        for (int c = 0; c < 3; c++) begin
            n_num[c] = (NumW'(i_side.mag[c]) << n_sh) + NumW'(i_root[31:1]);
        end
    end

    logic            r_p_vld;
    logic [31:0]     r_p_len;
    logic [NumW-1:0] r_p_num [0:2];
    t_side           r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_len  <= i_root;
        r_p_num  <= n_num;
        r_p_side <= n_side;
    end

    logic            r_vld  [1:Steps];
    logic [31:0]     r_len  [1:Steps];
    logic [NumW-1:0] r_rem  [1:Steps][0:2];
    logic [QuoW-1:0] r_q    [1:Steps][0:2];
    t_side           r_side [1:Steps];

    for (genvar g = 0; g < Steps; g++) begin : g_stage
        localparam int I = Steps - 1 - g;

        logic            c_vld;
        logic [31:0]     c_len;
        logic [NumW-1:0] c_rem [0:2];
        logic [QuoW-1:0] c_q   [0:2];
        t_side           c_side;
        logic [NumW-1:0] n_dsub;
        logic [2:0]      n_take;

        if (g == 0) begin : g_first
            assign c_vld  = r_p_vld;
            assign c_len  = r_p_len;
            assign c_rem  = r_p_num;
            assign c_side = r_p_side;
            for (genvar c = 0; c < 3; c++) begin : g_q0
                assign c_q[c] = '0;
            end
        end else begin : g_next
            assign c_vld  = r_vld[g];
            assign c_len  = r_len[g];
            assign c_rem  = r_rem[g];
            assign c_q    = r_q[g];
            assign c_side = r_side[g];
        end

        assign n_dsub = NumW'(c_len) << I;

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                n_take[c] = c_rem[c] >= n_dsub;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[g+1][c] <= n_take[c] ? (c_rem[c] - n_dsub) : c_rem[c];
                r_q[g+1][c]   <= {c_q[c][QuoW-2:0], n_take[c]};
            end
            r_len[g+1]  <= c_len;
            r_side[g+1] <= c_side;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_q[c] = r_q[Steps][c];
        end
    end

    assign o_vld  = r_vld[Steps];
    assign o_side = r_side[Steps];

endmodule

// ===== rtl/vector3_fixed_point_alu.sv =====
// an item passes through the front end, the square root, the divider and an output register (q16.16 by default)
// throughput: one item per cycle; busy is low whenever reset is released
// the depth is set by the 32-stage square root and the FRAC_BITS+1 divide stages
// results appear for one cycle on o_valid; the receiver cannot stall them
// reset (synchronous, active low) clears all valid bits; items in flight are dropped
module vector3_fixed_point_alu import vfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic signed [31:0] i_scalar,
    output logic               o_valid,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic signed [31:0] o_rz,
    output logic               o_flag
);

    // the pipe never backs up, so the only time an item is refused is reset
    logic acc;

    assign busy = ~i_rst_n;
    assign acc  = start & ~busy;

    // front end: six stages of multiply, sum, round and length normalizing
    logic        f_vld;
    logic [63:0] f_rad;
    t_side       f_side;

    vfa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_command (i_command),
        .i_ax      (i_ax),
        .i_ay      (i_ay),
        .i_az      (i_az),
        .i_bx      (i_bx),
        .i_by      (i_by),
        .i_bz      (i_bz),
        .i_scalar  (i_scalar),
        .o_vld     (f_vld),
        .o_rad     (f_rad),
        .o_side    (f_side)
    );

    // square root of the squared length (shifted up by 2k for normalize)
    logic        s_vld;
    logic [31:0] s_root;
    logic [32:0] s_rem;
    t_side       s_side;

    vfa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_rem   (s_rem),
        .o_side  (s_side)
    );

    // length rounding plus three component dividers for normalize
    logic                    d_vld;
    logic [2:0][FRAC_BITS:0] d_q;
    t_side                   d_side;

    vfa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_vld),
        .i_root  (s_root),
        .i_rem   (s_rem),
        .i_side  (s_side),
        .o_vld   (d_vld),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    // output stage: a nonzero normalize takes the signed quotients, all else
    // takes the result computed early and carried along; the quotient is at
    // most 2^FRAC_BITS so normalize never saturates
    logic [31:0] n_res [0:2];
    logic        n_use_div;

    always_comb begin
        n_use_div = (d_side.cmd == CMD_NORM) && !d_side.flag;
        for (int c = 0; c < 3; c++) begin
            if (n_use_div) begin
                n_res[c] = d_side.sgn[c] ? (32'd0 - 32'(d_q[c])) : 32'(d_q[c]);
            end else begin
                n_res[c] = d_side.res[c];
            end
        end
    end

    logic        r_vld;
    logic [31:0] r_rx;
    logic [31:0] r_ry;
    logic [31:0] r_rz;
    logic        r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx   <= n_res[0];
        r_ry   <= n_res[1];
        r_rz   <= n_res[2];
        r_flag <= d_side.flag;
    end

    assign o_valid = r_vld;
    assign o_rx    = r_rx;
    assign o_ry    = r_ry;
    assign o_rz    = r_rz;
    assign o_flag  = r_flag;

endmodule
